/* sv/boot_loop_watchdog_supervisor_core_defines.svh */
// ----------------------------------------------------------------------------
// Boot-loop watchdog supervisor assertion macros
// Shared assertion helpers; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BOOT_LOOP_WATCHDOG_SUPERVISOR_CORE_DEFINES_SVH
`define BOOT_LOOP_WATCHDOG_SUPERVISOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every rising edge outside of reset.
`define BLWD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Property must never hold at a rising edge outside of reset.
`define BLWD_ASSERT_NEVER(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");
`else
`define BLWD_ASSERT(name, prop)
`define BLWD_ASSERT_NEVER(name, prop)
`endif

`endif

/* sv/blwd_pkg.sv */
// ----------------------------------------------------------------------------
// Boot-loop watchdog supervisor package
// Shared types, command codes, reset reasons and register indexes.
// ----------------------------------------------------------------------------
package blwd_pkg;

  // Event codes carried on the input stream.
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_FEED    = 3'd1,
    CMD_BOOT    = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_RESTART = 3'd4
  } cmd_e;

  // Reset reasons reported with a boot event.
  localparam logic [3:0] REASON_POWERON  = 4'd0;
  localparam logic [3:0] REASON_EXTERNAL = 4'd1;
  localparam logic [3:0] REASON_BROWNOUT = 4'd2;
  localparam logic [3:0] REASON_SOFTWARE = 4'd3;
  localparam logic [3:0] REASON_TASK_WDT = 4'd4;
  localparam logic [3:0] REASON_WDT      = 4'd5;
  localparam logic [3:0] REASON_PANIC    = 4'd6;
  localparam logic [3:0] REASON_INT_WDT  = 4'd7;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STALL_LIMIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STABLE_WINDOW = 2'd2;

  localparam logic [7:0]  THRESHOLD_RESET     = 8'd3;
  localparam logic [23:0] STALL_LIMIT_RESET   = 24'd180000;
  localparam logic [23:0] STABLE_WINDOW_RESET = 24'd300000;

  typedef struct packed {
    logic [7:0]  boot_loop_threshold;
    logic [23:0] stall_limit_ms;
    logic [23:0] stable_window_ms;
  } cfg_t;

  typedef struct packed {
    logic       stall_detected;
    logic       restart_now;
    logic [7:0] loop_cnt;
    logic       safe_flag;
  } result_t;

endpackage

/* sv/boot_loop_watchdog_supervisor_core.sv */
// ----------------------------------------------------------------------------
// Boot-loop watchdog supervisor core
// Boot-loop counter, safe-mode control and loop-stall watchdog on a stream.
// ----------------------------------------------------------------------------
// Each input word is one event: a millisecond tick, a loop feed, a boot with
// its reset reason, a manual clear or a software restart request. Every event
// returns exactly one result word with the safe-mode flag, the boot-loop count
// and the restart and stall pulses. The block sustains one word per clock
// while the result side takes words: an event sits in an input register,
// the event engine applies it to the supervisor state, and the result
// lands in an output register, from which the result word is offered. The
// input side keeps accepting while a result waits if the input register is
// empty or the output register is freed in the same cycle. Reset acts as
// power-on: the supervisor state and valid flags clear and the configuration
// registers take their default values.
// ----------------------------------------------------------------------------
`include "boot_loop_watchdog_supervisor_core_defines.svh"

module boot_loop_watchdog_supervisor_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Event stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [3:0] boot_cause
  input  logic [2:0]                    s_axis_tuser,   // [2:0] cmd
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] safe_flag, [8:1] loop_cnt, [9] restart_now, [10] stall_detected
  output logic [15:0]                   m_axis_tdata,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [blwd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [blwd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import blwd_pkg::*;

  cfg_t        cfg;
  result_t     result;
  result_t     result_q;

  logic        in_valid_q;
  cmd_e        cmd_q;
  logic [3:0]  reason_q;
  logic        out_valid_q;

  logic        in_accept;
  logic        step;

  // The engine fires when an event is held and the output register is free
  // or being drained this cycle.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  blwd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  blwd_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cmd_i    (cmd_q),
    .reason_i (reason_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= cmd_e'(s_axis_tuser);
      reason_q <= s_axis_tdata[3:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, result_q};

  // A stall pulse always comes with a restart request.
  `BLWD_ASSERT(a_stall_implies_restart,
               out_valid_q && result_q.stall_detected |-> result_q.restart_now)
  // A processed event always leaves a result behind.
  `BLWD_ASSERT(a_step_loads_result, step |=> out_valid_q)
  // A held event is not dropped while the output side is blocked.
  `BLWD_ASSERT(a_event_kept_on_stall,
               in_valid_q && out_valid_q && !m_axis_tready |=> in_valid_q)
  // The engine never fires into a full, undrained output register.
  `BLWD_ASSERT_NEVER(a_no_overwrite, step && out_valid_q && !m_axis_tready)

endmodule

/* sv/blwd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Boot-loop watchdog supervisor configuration registers
// Holds the threshold and the two millisecond limits, written by index.
// ----------------------------------------------------------------------------
module blwd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [blwd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [blwd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output blwd_pkg::cfg_t               cfg_o
);
  import blwd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:     cfg_d.boot_loop_threshold = cfg_wdata_i[7:0];
        CFG_STALL_LIMIT:   cfg_d.stall_limit_ms      = cfg_wdata_i;
        CFG_STABLE_WINDOW: cfg_d.stable_window_ms    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boot_loop_threshold <= THRESHOLD_RESET;
      cfg_q.stall_limit_ms      <= STALL_LIMIT_RESET;
      cfg_q.stable_window_ms    <= STABLE_WINDOW_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/blwd_engine.sv */
// ----------------------------------------------------------------------------
// Boot-loop watchdog supervisor event engine
// Supervisor state and the combinational update for one event.
// ----------------------------------------------------------------------------
module blwd_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  blwd_pkg::cmd_e    cmd_i,
  input  logic [3:0]        reason_i,
  input  blwd_pkg::cfg_t    cfg_i,
  output blwd_pkg::result_t result_o
);
  import blwd_pkg::*;

  logic [7:0]  count_q, count_d;
  logic        mark_q, mark_d;
  logic        retained_q, retained_d;
  logic        safe_q, safe_d;
  logic [31:0] uptime_q, uptime_d;
  // Time since the last feed, kept directly instead of the feed timestamp.
  logic [31:0] since_feed_q, since_feed_d;
  logic        fed_q, fed_d;

  logic        restart;
  logic        stall;
  logic        timed_out;
  logic        stable;
  logic        wdt_boot;
  logic        clean_boot;
  logic [7:0]  boot_cnt;
  logic        boot_retained;

  // After the tick the elapsed time is since_feed_q + 1 (mod 2^32), so the
  // compare is done on the old value without an adder in front of it.
  assign timed_out = (since_feed_q != '1) &&
                     (since_feed_q >= {8'd0, cfg_i.stall_limit_ms});
  assign stable    = (uptime_q != '1) &&
                     (uptime_q >= {8'd0, cfg_i.stable_window_ms});

  always_comb begin
    wdt_boot   = 1'b0;
    clean_boot = 1'b0;
    case (reason_i) inside
      REASON_TASK_WDT, REASON_WDT, REASON_PANIC, REASON_INT_WDT: wdt_boot = 1'b1;
      REASON_SOFTWARE: begin
        wdt_boot   = mark_q;
        clean_boot = !mark_q;
      end
      REASON_POWERON, REASON_EXTERNAL, REASON_BROWNOUT: clean_boot = 1'b1;
      default: ;
    endcase

    boot_cnt      = count_q;
    boot_retained = retained_q;
    if (wdt_boot) begin
      if (count_q != 8'hFF) begin
        boot_cnt = count_q + 8'd1;
      end
    end else if (clean_boot) begin
      boot_cnt      = '0;
      boot_retained = 1'b0;
    end
  end

  always_comb begin
    count_d      = count_q;
    mark_d       = mark_q;
    retained_d   = retained_q;
    safe_d       = safe_q;
    uptime_d     = uptime_q;
    since_feed_d = since_feed_q;
    fed_d        = fed_q;
    restart      = 1'b0;
    stall        = 1'b0;
    case (cmd_i)
      CMD_TICK: begin
        uptime_d     = uptime_q + 32'd1;
        since_feed_d = since_feed_q + 32'd1;
        if (fed_q) begin
          if (timed_out) begin
            mark_d  = 1'b1;
            restart = 1'b1;
            stall   = 1'b1;
          end else if (stable && (count_q != '0 || safe_q)) begin
            count_d    = '0;
            retained_d = 1'b0;
            safe_d     = 1'b0;
          end
        end
      end
      CMD_FEED: begin
        since_feed_d = '0;
        fed_d        = 1'b1;
      end
      CMD_BOOT: begin
        uptime_d     = '0;
        since_feed_d = '0;
        fed_d        = 1'b0;
        mark_d       = 1'b0;
        count_d      = boot_cnt;
        if (boot_cnt >= cfg_i.boot_loop_threshold) begin
          retained_d = 1'b1;
          safe_d     = 1'b1;
        end else begin
          retained_d = boot_retained;
          safe_d     = boot_retained;
        end
      end
      CMD_CLEAR: begin
        count_d    = '0;
        retained_d = 1'b0;
        safe_d     = 1'b0;
        mark_d     = 1'b0;
      end
      CMD_RESTART: begin
        mark_d  = 1'b1;
        restart = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      mark_q       <= 1'b0;
      retained_q   <= 1'b0;
      safe_q       <= 1'b0;
      uptime_q     <= '0;
      since_feed_q <= '0;
      fed_q        <= 1'b0;
    end else if (step_i) begin
      count_q      <= count_d;
      mark_q       <= mark_d;
      retained_q   <= retained_d;
      safe_q       <= safe_d;
      uptime_q     <= uptime_d;
      since_feed_q <= since_feed_d;
      fed_q        <= fed_d;
    end
  end

  assign result_o.safe_flag      = safe_d;
  assign result_o.loop_cnt       = count_d;
  assign result_o.restart_now    = restart;
  assign result_o.stall_detected = stall;

endmodule
